### design/crc8_data_frame_builder_defines.svh
// Assertion macros shared by the frame builder RTL.
`ifndef CRC8_DATA_FRAME_BUILDER_DEFINES_SVH
`define CRC8_DATA_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication, checked on clk with reset masked.
`define CRC8FB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk with reset masked.
`define CRC8FB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/crc8fb_pkg.sv
// Package with constants, types and the CRC-8 step function of the frame builder.
package crc8fb_pkg;

    localparam int DATA_W            = 8;
    localparam int PAYLOAD_BYTES_DEF = 32;

    localparam logic [DATA_W-1:0] SYN_BYTE  = 8'h16;
    localparam logic [DATA_W-1:0] DC1_BYTE  = 8'h11;
    localparam logic [DATA_W-1:0] DC4_BYTE  = 8'h14;
    localparam logic [DATA_W-1:0] MARK_BYTE = 8'hFF;
    localparam logic [DATA_W-1:0] CRC_POLY  = 8'h07;

    // Input opcodes.
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Source of the next emitted word.
    typedef logic [2:0] sel_t;
    localparam sel_t SEL_SYN  = 3'd0;
    localparam sel_t SEL_DC1  = 3'd1;
    localparam sel_t SEL_DATA = 3'd2;
    localparam sel_t SEL_FILL = 3'd3;
    localparam sel_t SEL_CRC  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic clear_crc;
        logic emit;
        sel_t sel;
        logic advance;
        logic frame_end;
        logic run_last;
        logic close_frame;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic pos_zero;
        logic full_next;
        logic is_end;
    } sts_t;

    // One byte through the CRC-8 register, MSB first, no reflection.
    function automatic logic [DATA_W-1:0] crc8_update(input logic [DATA_W-1:0] crc,
                                                      input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < DATA_W; k++)
        begin
            if (c[DATA_W-1])
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

### design/crc8fb_dp.sv
// Datapath of the frame builder: item latch, frame position, CRC and output register.
module crc8fb_dp #(
    parameter int PAYLOAD_BYTES = crc8fb_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           opcode,
    input  logic [crc8fb_pkg::DATA_W-1:0]  payload_byte,
    input  crc8fb_pkg::cmd_t               cmd,
    output crc8fb_pkg::sts_t               sts,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [crc8fb_pkg::DATA_W-1:0]  frame_byte,
    output logic                           frame_end,
    output logic                           run_last
);
    import crc8fb_pkg::*;

    localparam int POS_W = $clog2(PAYLOAD_BYTES + 1);

    logic              op_reg;
    logic [DATA_W-1:0] byte_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_inc;
    logic [DATA_W-1:0] crc_reg;
    logic [DATA_W-1:0] crc_next;
    logic [DATA_W-1:0] data_word;
    logic [DATA_W-1:0] emit_word;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_byte_reg;
    logic              out_end_reg;
    logic              out_last_reg;

    // Latch the accepted word.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= opcode;
            byte_reg <= payload_byte;
        end
    end

    // Select the word to emit; end of input places the marker.
    assign data_word = (op_reg == OP_END) ? MARK_BYTE : byte_reg;

    always_comb
    begin
        case (cmd.sel)
            SEL_SYN:  emit_word = SYN_BYTE;
            SEL_DC1:  emit_word = DC1_BYTE;
            SEL_DATA: emit_word = data_word;
            SEL_FILL: emit_word = DC4_BYTE;
            SEL_CRC:  emit_word = crc_reg;
            default:  emit_word = crc_reg;
        endcase
    end

    assign pos_inc  = pos_reg + POS_W'(1);
    assign crc_next = crc8_update(crc_reg, emit_word);

    // Frame position and running CRC of the payload region.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= '0;
        end
        else if (cmd.close_frame)
        begin
            pos_reg <= '0;
            crc_reg <= '0;
        end
        else if (cmd.advance)
        begin
            pos_reg <= pos_inc;
            crc_reg <= crc_next;
        end
        else if (cmd.clear_crc)
        begin
            crc_reg <= '0;
        end
    end

    // Output register: loaded when the controller emits, freed when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg <= emit_word;
            out_end_reg  <= cmd.frame_end;
            out_last_reg <= cmd.run_last;
        end
    end

    // Status for the controller.
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.pos_zero  = (pos_reg == '0);
    assign sts.full_next = (pos_inc >= POS_W'(PAYLOAD_BYTES));
    assign sts.is_end    = (op_reg == OP_END);

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign frame_end  = out_end_reg;
    assign run_last   = out_last_reg;

endmodule

### design/crc8fb_ctrl.sv
// Controller of the frame builder: sequences header, payload, fill and CRC words.
module crc8fb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  crc8fb_pkg::sts_t sts,
    output crc8fb_pkg::cmd_t cmd
);
    import crc8fb_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SYN  = 3'd1;
    localparam logic [2:0] ST_DC1  = 3'd2;
    localparam logic [2:0] ST_DATA = 3'd3;
    localparam logic [2:0] ST_FILL = 3'd4;
    localparam logic [2:0] ST_CRC  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state and commands; every emitting state waits for a free output slot.
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.sel         = SEL_DATA;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    if (sts.pos_zero)
                    begin
                        cmd.clear_crc = 1'b1;
                        state_next    = ST_SYN;
                    end
                    else
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_SYN:
            begin
                cmd.sel = SEL_SYN;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_DC1;
                end
            end
            ST_DC1:
            begin
                cmd.sel = SEL_DC1;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                cmd.sel = SEL_DATA;
                if (sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.advance = 1'b1;
                    if (sts.full_next)
                    begin
                        state_next = ST_CRC;
                    end
                    else if (sts.is_end)
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        cmd.run_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.sel = SEL_FILL;
                if (sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.advance = 1'b1;
                    if (sts.full_next)
                    begin
                        state_next = ST_CRC;
                    end
                end
            end
            ST_CRC:
            begin
                cmd.sel = SEL_CRC;
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.frame_end   = 1'b1;
                    cmd.run_last    = 1'b1;
                    cmd.close_frame = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/crc8_data_frame_builder.sv
// Top level of the CRC-8 frame builder: controller, datapath and checks.
//
//  channel | handshake             | word fields
//  --------+-----------------------+------------------------------------
//  in      | in_valid / in_ready   | opcode, payload_byte
//  out     | out_valid / out_ready | frame_byte, frame_end, run_last
//
// An input word is accepted in the idle state; the controller then emits each
// output word it produces: a payload word gives its data word (with the header
// or CRC word at a frame edge), an end-of-input word its marker, fill and CRC. The
// controller emits at most one word per cycle into the single output register,
// which sets the rate. A stalled output holds the controller in its current
// state. Reset empties the output register and closes any open frame.
module crc8_data_frame_builder #(
    parameter int PAYLOAD_BYTES = crc8fb_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [crc8fb_pkg::DATA_W-1:0]  payload_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [crc8fb_pkg::DATA_W-1:0]  frame_byte,
    output logic                           frame_end,
    output logic                           run_last
);
    import crc8fb_pkg::*;

    `include "crc8_data_frame_builder_defines.svh"

    cmd_t cmd;
    sts_t sts;

    crc8fb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    crc8fb_dp #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .opcode       (opcode),
        .payload_byte (payload_byte),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_byte   (frame_byte),
        .frame_end    (frame_end),
        .run_last     (run_last)
    );

    // Every accepted word produces at least one output word, so ready drops.
    `CRC8FB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

    // A CRC word always closes the run of its input word.
    `CRC8FB_ASSERT_NOW(a_crc_is_last, out_valid && frame_end, run_last, "CRC word not last")

    // Emitting never overwrites a pending word that is not being taken.
    `CRC8FB_ASSERT_NOW(a_no_overwrite, cmd.emit, !out_valid || out_ready, "output overwritten")

endmodule
